// ----- rtl/fsnp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_pkg: shared types and constants of the format string number printer
// Character codes, controller states, datapath command and status bundles.
// ----------------------------------------------------------------------------
package fsnp_pkg;

    localparam int ARG_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int DEC_DIGITS = 20;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int CNT_W      = $clog2(ARG_W);
    localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
    localparam int HEX_IDX_W  = 4;

    // default hex field widths
    localparam int HEX_DIGITS_LONG  = 16;
    localparam int HEX_DIGITS_SHORT = 8;
    localparam logic [DIG_IDX_W-1:0] DIG_TOP       = DIG_IDX_W'(DEC_DIGITS - 1);
    localparam logic [CNT_W-1:0]     CNT_LAST      = CNT_W'(ARG_W - 1);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_L     = 8'h6C;
    localparam logic [CHAR_W-1:0] CHAR_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHR,
        ST_CONV,
        ST_SIGN,
        ST_DEC,
        ST_HEX0,
        ST_HEXX,
        ST_HEXD
    } state_t;

    typedef enum logic [2:0] {
        SEL_IN,
        SEL_CHR,
        SEL_MINUS,
        SEL_ZERO,
        SEL_X,
        SEL_DEC,
        SEL_HEX
    } sel_t;

    typedef struct packed {
        logic load;       // latch input char and argument
        logic sgn;        // signed conversion
        logic lng;        // long form
        logic conv_step;  // one binary-to-BCD shift
        logic emit;       // write a char into the output register
        sel_t sel;
        logic last;
        logic dec_adv;    // move to next lower decimal digit
        logic hex_adv;    // move to next lower hex digit
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic conv_last;
        logic neg;
        logic dig_zero;
        logic dig_idx_zero;
        logic started;
        logic hex_idx_zero;
    } stat_t;

endpackage
`default_nettype wire

// ----- rtl/fsnp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_ctrl: format parser and sequencer
// Tracks the open specifier and long flag, and steps the datapath through
// conversion and character output.
// ----------------------------------------------------------------------------
module fsnp_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [fsnp_pkg::CHAR_W-1:0]    in_char,
    output logic                                in_ready,
    input  wire fsnp_pkg::stat_t                stat,
    output fsnp_pkg::cmd_t                      cmd
);

    fsnp_pkg::state_t state_reg, state_next;
    logic in_spec_reg, in_spec_next;
    logic long_reg, long_next;

    logic accept;
    logic echo;
    logic start_dec;
    logic start_hex;
    logic dec_skip;

    assign in_ready = (state_reg == fsnp_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        echo      = accept && (in_char != fsnp_pkg::CHAR_NUL) &&
                    ((in_spec_reg && (in_char == fsnp_pkg::CHAR_PCT)) ||
                     (!in_spec_reg && (in_char != fsnp_pkg::CHAR_PCT)));
        start_dec = accept && in_spec_reg &&
                    ((in_char == fsnp_pkg::CHAR_D) || (in_char == fsnp_pkg::CHAR_U));
        start_hex = accept && in_spec_reg && (in_char == fsnp_pkg::CHAR_X);
        // leading zeros are dropped, the units digit always prints
        dec_skip  = !stat.started && stat.dig_zero && !stat.dig_idx_zero;
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        in_spec_next = in_spec_reg;
        long_next    = long_reg;
        case (state_reg)
            fsnp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_char == fsnp_pkg::CHAR_NUL)
                    begin
                        in_spec_next = 1'b0;
                        long_next    = 1'b0;
                    end
                    else if (in_spec_reg)
                    begin
                        in_spec_next = 1'b0;
                        if (in_char == fsnp_pkg::CHAR_L)
                        begin
                            in_spec_next = 1'b1;
                            long_next    = 1'b1;
                        end
                    end
                    else if (in_char == fsnp_pkg::CHAR_PCT)
                    begin
                        in_spec_next = 1'b1;
                        long_next    = 1'b0;
                    end
                end
                if (echo && !stat.out_free)
                    state_next = fsnp_pkg::ST_CHR;
                else if (start_dec)
                    state_next = fsnp_pkg::ST_CONV;
                else if (start_hex)
                    state_next = fsnp_pkg::ST_HEX0;
            end
            fsnp_pkg::ST_CHR:
            begin
                if (stat.out_free)
                    state_next = fsnp_pkg::ST_IDLE;
            end
            fsnp_pkg::ST_CONV:
            begin
                if (stat.conv_last)
                    state_next = stat.neg ? fsnp_pkg::ST_SIGN : fsnp_pkg::ST_DEC;
            end
            fsnp_pkg::ST_SIGN:
            begin
                if (stat.out_free)
                    state_next = fsnp_pkg::ST_DEC;
            end
            fsnp_pkg::ST_DEC:
            begin
                if (!dec_skip && stat.out_free && stat.dig_idx_zero)
                    state_next = fsnp_pkg::ST_IDLE;
            end
            fsnp_pkg::ST_HEX0:
            begin
                if (stat.out_free)
                    state_next = fsnp_pkg::ST_HEXX;
            end
            fsnp_pkg::ST_HEXX:
            begin
                if (stat.out_free)
                    state_next = fsnp_pkg::ST_HEXD;
            end
            fsnp_pkg::ST_HEXD:
            begin
                if (stat.out_free && stat.hex_idx_zero)
                    state_next = fsnp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsnp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.sel       = fsnp_pkg::SEL_IN;
        cmd.sgn       = (in_char == fsnp_pkg::CHAR_D);
        cmd.lng       = long_reg;
        case (state_reg)
            fsnp_pkg::ST_IDLE:
            begin
                cmd.load = accept;
                if (echo && stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = fsnp_pkg::SEL_IN;
                    cmd.last = 1'b1;
                end
            end
            fsnp_pkg::ST_CHR:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = fsnp_pkg::SEL_CHR;
                cmd.last = 1'b1;
            end
            fsnp_pkg::ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            fsnp_pkg::ST_SIGN:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = fsnp_pkg::SEL_MINUS;
            end
            fsnp_pkg::ST_DEC:
            begin
                cmd.sel = fsnp_pkg::SEL_DEC;
                if (dec_skip)
                    cmd.dec_adv = 1'b1;
                else if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.last    = stat.dig_idx_zero;
                    cmd.dec_adv = !stat.dig_idx_zero;
                end
            end
            fsnp_pkg::ST_HEX0:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = fsnp_pkg::SEL_ZERO;
            end
            fsnp_pkg::ST_HEXX:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = fsnp_pkg::SEL_X;
            end
            fsnp_pkg::ST_HEXD:
            begin
                cmd.sel = fsnp_pkg::SEL_HEX;
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.last    = stat.hex_idx_zero;
                    cmd.hex_adv = !stat.hex_idx_zero;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fsnp_pkg::ST_IDLE;
            in_spec_reg <= 1'b0;
            long_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_spec_reg <= in_spec_next;
            long_reg    <= long_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fsnp_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnp_dpath: conversion datapath and output register
// Magnitude prep, shift-and-add-3 binary to BCD, digit selection and the
// output character register.
// ----------------------------------------------------------------------------
module fsnp_dpath #(
    parameter int HEX_DIGITS_LONG  = fsnp_pkg::HEX_DIGITS_LONG,
    parameter int HEX_DIGITS_SHORT = fsnp_pkg::HEX_DIGITS_SHORT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [fsnp_pkg::CHAR_W-1:0]    fmt_char,
    input  wire logic [fsnp_pkg::ARG_W-1:0]     arg_value,
    input  wire fsnp_pkg::cmd_t                 cmd,
    output fsnp_pkg::stat_t                     stat,
    output logic                                out_valid,
    output logic [fsnp_pkg::CHAR_W-1:0]         out_char,
    output logic                                out_last,
    input  wire logic                           out_ready
);

    // hex field widths, clamped to 1..16 digits
    localparam int IDX_W       = fsnp_pkg::HEX_IDX_W;
    localparam int HEX_LONG_N  = (HEX_DIGITS_LONG < 1) ? 1 :
                                 ((HEX_DIGITS_LONG > 16) ? 16 : HEX_DIGITS_LONG);
    localparam int HEX_SHORT_N = (HEX_DIGITS_SHORT < 1) ? 1 :
                                 ((HEX_DIGITS_SHORT > 16) ? 16 : HEX_DIGITS_SHORT);
    localparam logic [IDX_W-1:0] HEX_LONG_TOP  = IDX_W'(HEX_LONG_N - 1);
    localparam logic [IDX_W-1:0] HEX_SHORT_TOP = IDX_W'(HEX_SHORT_N - 1);

    logic [fsnp_pkg::ARG_W-1:0]     val_reg, val_next;
    logic [fsnp_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [fsnp_pkg::CHAR_W-1:0]    char_reg;
    logic                           neg_reg;
    logic [fsnp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [fsnp_pkg::DIG_IDX_W-1:0] dig_idx_reg, dig_idx_next;
    logic [fsnp_pkg::HEX_IDX_W-1:0] hex_idx_reg, hex_idx_next;
    logic                           started_reg, started_next;
    logic                           ovalid_reg, ovalid_next;
    logic [fsnp_pkg::CHAR_W-1:0]    ochar_reg;
    logic                           olast_reg;

    logic [fsnp_pkg::ARG_W-1:0]     ext;
    logic                           neg;
    logic [fsnp_pkg::BCD_W-1:0]     bcd_adj;
    logic [3:0]                     dig;
    logic [3:0]                     nib;
    logic [fsnp_pkg::CHAR_W-1:0]    char_sel;

    // short forms extend the low word
    always_comb
    begin
        ext = cmd.lng ? arg_value :
              {{32{cmd.sgn & arg_value[31]}}, arg_value[31:0]};
        neg = cmd.sgn & ext[fsnp_pkg::ARG_W-1];
    end

    always_comb
    begin
        for (int i = 0; i < fsnp_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign dig = 4'(bcd_reg >> {dig_idx_reg, 2'b00});
    assign nib = 4'(val_reg >> {hex_idx_reg, 2'b00});

    always_comb
    begin
        case (cmd.sel)
            fsnp_pkg::SEL_IN:    char_sel = fmt_char;
            fsnp_pkg::SEL_CHR:   char_sel = char_reg;
            fsnp_pkg::SEL_MINUS: char_sel = fsnp_pkg::CHAR_MINUS;
            fsnp_pkg::SEL_ZERO:  char_sel = fsnp_pkg::CHAR_ZERO;
            fsnp_pkg::SEL_X:     char_sel = fsnp_pkg::CHAR_X;
            fsnp_pkg::SEL_DEC:   char_sel = fsnp_pkg::CHAR_ZERO + {4'd0, dig};
            fsnp_pkg::SEL_HEX:
            begin
                if (nib <= 4'd9)
                    char_sel = fsnp_pkg::CHAR_ZERO + {4'd0, nib};
                else
                    char_sel = fsnp_pkg::CHAR_UPA + {4'd0, nib - 4'd10};
            end
            default:             char_sel = fsnp_pkg::CHAR_ZERO;
        endcase
    end

    always_comb
    begin
        val_next     = val_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        dig_idx_next = dig_idx_reg;
        hex_idx_next = hex_idx_reg;
        started_next = started_reg;
        if (cmd.load)
        begin
            val_next     = neg ? (~ext + 64'd1) : ext;
            bcd_next     = '0;
            cnt_next     = '0;
            dig_idx_next = fsnp_pkg::DIG_TOP;
            hex_idx_next = cmd.lng ? HEX_LONG_TOP : HEX_SHORT_TOP;
            started_next = 1'b0;
        end
        if (cmd.conv_step)
        begin
            bcd_next = {bcd_adj[fsnp_pkg::BCD_W-2:0], val_reg[fsnp_pkg::ARG_W-1]};
            val_next = {val_reg[fsnp_pkg::ARG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.dec_adv)
            dig_idx_next = dig_idx_reg - 1'b1;
        if (cmd.hex_adv)
            hex_idx_next = hex_idx_reg - 1'b1;
        if (cmd.emit && (cmd.sel == fsnp_pkg::SEL_DEC))
            started_next = 1'b1;
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.emit)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg  <= 1'b0;
            cnt_reg     <= '0;
            dig_idx_reg <= '0;
            hex_idx_reg <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg  <= ovalid_next;
            cnt_reg     <= cnt_next;
            dig_idx_reg <= dig_idx_next;
            hex_idx_reg <= hex_idx_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        bcd_reg <= bcd_next;
        if (cmd.load)
        begin
            char_reg <= fmt_char;
            neg_reg  <= neg;
        end
        if (cmd.emit)
        begin
            ochar_reg <= char_sel;
            olast_reg <= cmd.last;
        end
    end

    always_comb
    begin
        stat.out_free     = !ovalid_reg || out_ready;
        stat.conv_last    = (cnt_reg == fsnp_pkg::CNT_LAST);
        stat.neg          = neg_reg;
        stat.dig_zero     = (dig == 4'd0);
        stat.dig_idx_zero = (dig_idx_reg == '0);
        stat.started      = started_reg;
        stat.hex_idx_zero = (hex_idx_reg == '0);
    end

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;

endmodule
`default_nettype wire

// ----- rtl/format_string_number_printer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// format_string_number_printer: printf-style number formatter
// Turns a stream of format characters with argument values into ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one format character plus its 64-bit argument per
//   transfer. Master side gives one ASCII character per transfer; tlast marks
//   the final character caused by one input transfer. Inputs that print
//   nothing ('%', 'l', NUL, 's', unknown specifiers) give no master transfer.
//   Plain characters and "%%" are written into the output register in the
//   accepting cycle when it is free or being read, otherwise they wait until
//   it is. %d and %u run a shift-and-add-3 converter at one argument bit per
//   cycle over all 64 bits, then print '-' for a negative value, followed by
//   the decimal positions from the top (20 of them), skipping leading zeros
//   without output. %x prints "0x" and then one character per hex digit.
//   The next input is taken once the last character of the current one sits
//   in the output register.
//   A stalled receiver holds the output register and the sequencer waits on
//   it. Reset clears the specifier state and empties the output register.
// ----------------------------------------------------------------------------
module format_string_number_printer #(
    parameter int HEX_DIGITS_LONG  = fsnp_pkg::HEX_DIGITS_LONG,
    parameter int HEX_DIGITS_SHORT = fsnp_pkg::HEX_DIGITS_SHORT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [7:0] fmt_char, [71:8] arg_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic             m_tlast    // last_char
);

    fsnp_pkg::cmd_t  cmd;
    fsnp_pkg::stat_t stat;

    fsnp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_char  (s_tdata[7:0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fsnp_dpath #(
        .HEX_DIGITS_LONG  (HEX_DIGITS_LONG),
        .HEX_DIGITS_SHORT (HEX_DIGITS_SHORT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_char  (s_tdata[7:0]),
        .arg_value (s_tdata[71:8]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    // a character is never written over one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("char written into busy output register");

    a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv_step |-> (!cmd.emit && !s_tready))
        else $error("output or input activity during conversion");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.sel == fsnp_pkg::SEL_DEC)) |->
        (stat.started || !stat.dig_zero || stat.dig_idx_zero))
        else $error("leading zero printed");

endmodule
`default_nettype wire

// ----- verif/format_string_number_printer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_string_number_printer_tb: self-checking bench for the number printer
// Feeds format characters with 64-bit arguments, predicts the printed text
// per transfer and checks every output character and its tlast flag in order.
// Directed cases first, then random format sequences with bursty input and a
// stalling receiver, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module format_string_number_printer_tb;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 150;
    localparam int TOTAL_ITEMS   = 300;

    // hex widths as the printer clamps them
    localparam int HEX_LONG_W  = (fsnp_pkg::HEX_DIGITS_LONG < 1) ? 1 :
                                 ((fsnp_pkg::HEX_DIGITS_LONG > 16) ? 16 :
                                  fsnp_pkg::HEX_DIGITS_LONG);
    localparam int HEX_SHORT_W = (fsnp_pkg::HEX_DIGITS_SHORT < 1) ? 1 :
                                 ((fsnp_pkg::HEX_DIGITS_SHORT > 16) ? 16 :
                                  fsnp_pkg::HEX_DIGITS_SHORT);

    localparam logic [7:0] CHAR_S_CONV = 8'h73;   // 's', string conversion, prints nothing
    localparam logic [7:0] CHAR_Q_CONV = 8'h71;   // 'q', not a conversion

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } text_char_t;

    class text_scoreboard;
        text_char_t expected_text[$];
        bit         in_spec;
        bit         long_fmt;
        int         n_errors;

        function new();
            in_spec  = 0;
            long_fmt = 0;
            n_errors = 0;
        endfunction

        function void append_decimal(ref logic [7:0] txt[$], input logic [63:0] v);
            logic [7:0] rev[$];
            if (v == 64'd0)
            begin
                txt.push_back(fsnp_pkg::CHAR_ZERO);
                return;
            end
            while (v != 64'd0)
            begin
                rev.push_front(fsnp_pkg::CHAR_ZERO + 8'(v % 64'd10));
                v = v / 64'd10;
            end
            foreach (rev[i])
                txt.push_back(rev[i]);
        endfunction

        function void note_format_char(logic [7:0] ch, logic [63:0] arg);
            logic [7:0]  txt[$];
            logic [63:0] v;
            logic [3:0]  nib;
            int          ndig;
            if (ch == fsnp_pkg::CHAR_NUL)
            begin
                in_spec  = 0;
                long_fmt = 0;
            end
            else if (in_spec)
            begin
                in_spec = 0;
                case (ch)
                    fsnp_pkg::CHAR_D:
                    begin
                        v = long_fmt ? arg : {{32{arg[31]}}, arg[31:0]};
                        if (v[63])
                        begin
                            txt.push_back(fsnp_pkg::CHAR_MINUS);
                            v = ~v + 64'd1;
                        end
                        append_decimal(txt, v);
                    end
                    fsnp_pkg::CHAR_U:
                        append_decimal(txt, long_fmt ? arg : {32'd0, arg[31:0]});
                    fsnp_pkg::CHAR_X:
                    begin
                        v    = long_fmt ? arg : {32'd0, arg[31:0]};
                        ndig = long_fmt ? HEX_LONG_W : HEX_SHORT_W;
                        txt.push_back(fsnp_pkg::CHAR_ZERO);
                        txt.push_back(fsnp_pkg::CHAR_X);
                        for (int i = ndig - 1; i >= 0; i--)
                        begin
                            nib = 4'(v >> (4 * i));
                            txt.push_back(nib <= 4'd9 ?
                                          fsnp_pkg::CHAR_ZERO + 8'(nib) :
                                          fsnp_pkg::CHAR_UPA + 8'(nib) - 8'd10);
                        end
                    end
                    fsnp_pkg::CHAR_PCT: txt.push_back(fsnp_pkg::CHAR_PCT);
                    fsnp_pkg::CHAR_L:
                    begin
                        in_spec  = 1;
                        long_fmt = 1;
                    end
                    default: ;
                endcase
            end
            else if (ch == fsnp_pkg::CHAR_PCT)
            begin
                in_spec  = 1;
                long_fmt = 0;
            end
            else
            begin
                txt.push_back(ch);
            end
            foreach (txt[i])
                expected_text.push_back('{out_char: txt[i], last_char: (i == txt.size() - 1)});
        endfunction

        function void check_out_char(logic [7:0] c, logic l);
            text_char_t exp_c;
            if (expected_text.size() == 0)
            begin
                $error("unexpected output transfer: out_char %h last_char %b", c, l);
                n_errors++;
                return;
            end
            exp_c = expected_text.pop_front();
            if (c !== exp_c.out_char)
            begin
                $error("out_char: expected %h, got %h", exp_c.out_char, c);
                n_errors++;
            end
            if (l !== exp_c.last_char)
            begin
                $error("last_char: expected %b, got %b", exp_c.last_char, l);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;     // [7:0] fmt_char, [71:8] arg_value
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [7:0] out_char
    logic        m_tlast;     // last_char

    text_scoreboard sb;
    int  cycles;
    int  burst_left;
    int  sent_items;
    bit  hold_req;
    bit  hold_done;

    format_string_number_printer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one format character per transfer; sender may idle between bursts
    task automatic send_fmt_char(input logic [7:0] ch, input logic [63:0] arg);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {arg, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_format_char(ch, arg);
        sent_items++;
        @(negedge clk);
        burst_left--;
    endtask

    function automatic logic [63:0] pick_arg();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = 64'($urandom_range(0, 99));
            2: v = '1;
            3: v = 64'h8000_0000_0000_0000;
            4: v = {v[63:32], 32'h8000_0000};
            5: v = {v[63:32], 32'hFFFF_FFFF};
            6: v = {v[63:32], 1'b0, v[30:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_conv();
        case ($urandom_range(0, 9))
            0, 1, 2: return fsnp_pkg::CHAR_D;
            3, 4:    return fsnp_pkg::CHAR_U;
            5, 6:    return fsnp_pkg::CHAR_X;
            7:       return fsnp_pkg::CHAR_PCT;
            8:       return CHAR_S_CONV;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // receiver: stretches of differing readiness, one long hold-off on request
    initial
    begin
        int mode;
        int len;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 150);
            for (int k = 0; k < len; k++)
            begin
                @(negedge clk);
                if (hold_req && !hold_done)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((k % 8) < 5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_out_char(m_tdata, m_tlast);
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** format_string_number_printer: FAILED **");
        $finish;
    end

    initial
    begin
        int kind;
        sb             = new();
        burst_left     = 0;
        sent_items     = 0;
        hold_req       = 0;
        hold_done      = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes of each conversion and the special cases
        send_fmt_char(8'hFF, '1);
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_D, 64'd0);                     // zero prints one digit
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_D, 64'h1234_5678_FFFF_FFFF);   // short -1
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_L, '0);
        send_fmt_char(fsnp_pkg::CHAR_L, '0);                        // repeated l stays long
        send_fmt_char(fsnp_pkg::CHAR_D, 64'h8000_0000_0000_0000);   // most negative long
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_L, '0);
        send_fmt_char(fsnp_pkg::CHAR_U, '1);                        // 20 digits
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_X, 64'hFFFF_FFFF_DEAD_BEEF);   // short hex, low half
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_L, '0);
        send_fmt_char(fsnp_pkg::CHAR_X, 64'd0);
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_PCT, '1);
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(CHAR_S_CONV, '1);
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(CHAR_Q_CONV, '1);
        send_fmt_char(fsnp_pkg::CHAR_PCT, '0);
        send_fmt_char(fsnp_pkg::CHAR_L, '0);
        send_fmt_char(fsnp_pkg::CHAR_NUL, '1);                      // NUL drops the specifier
        send_fmt_char(fsnp_pkg::CHAR_D, '1);                        // now a plain character

        // random format sequences; receiver holds off early on
        hold_req = 1;
        while (sent_items < TOTAL_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                send_fmt_char(8'($urandom_range(32, 126)), pick_arg());
            end
            else if (kind <= 7)
            begin
                send_fmt_char(fsnp_pkg::CHAR_PCT, pick_arg());
                if ($urandom_range(0, 1))
                    send_fmt_char(fsnp_pkg::CHAR_L, pick_arg());
                if ($urandom_range(0, 7) == 0)
                    send_fmt_char(fsnp_pkg::CHAR_L, pick_arg());
                send_fmt_char(pick_conv(), pick_arg());
            end
            else if (kind == 8)
            begin
                send_fmt_char(8'($urandom_range(0, 255)), pick_arg());
            end
            else
            begin
                // broken specifier ended by NUL
                send_fmt_char(fsnp_pkg::CHAR_PCT, pick_arg());
                if ($urandom_range(0, 1))
                    send_fmt_char(fsnp_pkg::CHAR_L, pick_arg());
                send_fmt_char(fsnp_pkg::CHAR_NUL, pick_arg());
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected characters never arrived", sb.pending());
            sb.n_errors++;
        end
        if (sb.n_errors == 0)
            $display("** format_string_number_printer: PASSED **");
        else
            $display("** format_string_number_printer: FAILED **");
        $finish;
    end

endmodule
